/* hw/rtl/srpb_pkg.sv */
`timescale 1ns / 1ps
package srpb_pkg;

  // signed screen coordinate, wide enough for any centring offset and scaled position
  localparam int COORD_W = 14;
  localparam int SCALE_W = 4;
  localparam int WIDTH_W = 9;
  localparam int HEIGHT_W = 8;
  localparam int COLOR_W = 24;
  localparam int OFFSET_W = 19;
  localparam int BYTES_PER_PIXEL = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int PADDR_W = 4;
  localparam logic [1:0] REG_RENDER_WIDTH = 2'd0;
  localparam logic [1:0] REG_RENDER_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SCALE_FACTOR = 2'd2;

  localparam logic [WIDTH_W-1:0] RENDER_WIDTH_RST = 9'd200;
  localparam logic [HEIGHT_W-1:0] RENDER_HEIGHT_RST = 8'd120;
  localparam logic [SCALE_W-1:0] SCALE_FACTOR_RST = 4'd2;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic [WIDTH_W-1:0] render_width;
    logic [HEIGHT_W-1:0] render_height;
    logic [SCALE_W-1:0] scale_factor;
  } cfg_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    coord_t sx0;
    coord_t sy0;
    logic [SCALE_W-1:0] scale;
  } q_entry_t;

  typedef struct packed {
    logic valid;
    q_entry_t entry;
  } q_slot_t;

endpackage

/* hw/rtl/srpb_if.sv */
`timescale 1ns / 1ps
interface srpb_px_if;
  logic valid;
  logic ready;
  logic [23:0] pixel_color;

  modport source(output valid, output pixel_color, input ready);
  modport sink(input valid, input pixel_color, output ready);
endinterface

interface srpb_rep_if;
  logic valid;
  logic ready;
  logic [18:0] byte_offset;
  logic [7:0] blue_byte;
  logic [7:0] green_byte;
  logic [7:0] red_byte;
  logic in_bounds;
  logic last_replica;

  modport source(
    output valid, output byte_offset, output blue_byte, output green_byte,
    output red_byte, output in_bounds, output last_replica, input ready
  );
  modport sink(
    input valid, input byte_offset, input blue_byte, input green_byte,
    input red_byte, input in_bounds, input last_replica, output ready
  );
endinterface

/* hw/rtl/srpb_front.sv */
`timescale 1ns / 1ps
module srpb_front
  import srpb_pkg::*;
#(
  parameter int MAX_SCALE = 8,
  parameter int SCREEN_WIDTH = 400,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cfg_t          cfg,
  srpb_px_if.sink       in_px,
  output q_slot_t       push,
  input  logic          push_ready
);

  logic [WIDTH_W-1:0] col_r, col_nxt;
  logic [HEIGHT_W-1:0] row_r, row_nxt;
  logic [SCALE_W-1:0] s_eff;
  logic [WIDTH_W-1:0] w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic [WIDTH_W+SCALE_W-1:0] ws, cs;
  logic [HEIGHT_W+SCALE_W-1:0] hs, rs;
  coord_t left, top;
  logic accept;

  always_comb begin
    if (cfg.scale_factor == '0) begin
      s_eff = SCALE_W'(1);
    end else if (cfg.scale_factor > SCALE_W'(MAX_SCALE)) begin
      s_eff = SCALE_W'(MAX_SCALE);
    end else begin
      s_eff = cfg.scale_factor;
    end
    w_eff = (cfg.render_width == '0) ? WIDTH_W'(1) : cfg.render_width;
    h_eff = (cfg.render_height == '0) ? HEIGHT_W'(1) : cfg.render_height;
  end

  // centring offsets, floor halving of a signed difference
  assign ws = w_eff * s_eff;
  assign hs = h_eff * s_eff;
  assign cs = col_r * s_eff;
  assign rs = row_r * s_eff;
  assign left = (coord_t'(SCREEN_WIDTH) - coord_t'(ws)) >>> 1;
  assign top = (coord_t'(SCREEN_HEIGHT) - coord_t'(hs)) >>> 1;

  assign accept = in_px.valid && push_ready;
  assign in_px.ready = push_ready;

  always_comb begin
    push.valid = in_px.valid;
    push.entry.color = in_px.pixel_color;
    push.entry.sx0 = left + coord_t'(cs);
    push.entry.sy0 = top + coord_t'(rs);
    push.entry.scale = s_eff;
  end

  // raster counters, wrap when the next position reaches the size
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if ({1'b0, col_r} + 10'd1 >= {1'b0, w_eff}) begin
        col_nxt = '0;
        if ({1'b0, row_r} + 9'd1 >= {1'b0, h_eff}) begin
          row_nxt = '0;
        end else begin
          row_nxt = row_r + HEIGHT_W'(1);
        end
      end else begin
        col_nxt = col_r + WIDTH_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

/* hw/rtl/srpb_queue.sv */
`timescale 1ns / 1ps
module srpb_queue
  import srpb_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  q_slot_t push,
  output logic    push_ready,
  output q_slot_t head,
  input  logic    pop
);

  q_entry_t mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign push_ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign do_push = push.valid && push_ready;
  assign do_pop = pop && (cnt_r != '0);
  assign head.valid = (cnt_r != '0);
  assign head.entry = mem_r[rd_r];

  always_comb begin
    wr_nxt = wr_r;
    rd_nxt = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_r <= wr_nxt;
      rd_r <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* hw/rtl/srpb_back.sv */
`timescale 1ns / 1ps
module srpb_back
  import srpb_pkg::*;
#(
  parameter int SCREEN_WIDTH = 400,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic        clk,
  input  logic        rst_n,
  input  q_slot_t     head,
  output logic        pop,
  srpb_rep_if.source  out_rep
);

  localparam int COLUMN_BYTES = BYTES_PER_PIXEL * SCREEN_HEIGHT;

  logic busy_r, busy_nxt;
  q_entry_t cur_r;
  logic [SCALE_W-1:0] xs_r, xs_nxt, ys_r, ys_nxt;
  logic out_free, emit, last, load;
  coord_t sx, sy;
  logic on_screen;
  logic [31:0] off_full;

  logic out_valid_r;
  logic [OFFSET_W-1:0] off_r;
  logic [7:0] blue_r, green_r, red_r;
  logic inb_r, last_r;

  assign out_free = !out_valid_r || out_rep.ready;
  assign emit = busy_r && out_free;
  assign last = (xs_r == cur_r.scale - SCALE_W'(1)) && (ys_r == cur_r.scale - SCALE_W'(1));
  assign load = head.valid && (!busy_r || (emit && last));
  assign pop = load;

  assign sx = cur_r.sx0 + coord_t'(xs_r);
  assign sy = cur_r.sy0 + coord_t'(ys_r);
  assign on_screen = (sx >= 0) && (sx < coord_t'(SCREEN_WIDTH)) &&
                     (sy >= 0) && (sy < coord_t'(SCREEN_HEIGHT));
  // column-major with y flipped
  assign off_full = 32'(sx[COORD_W-2:0]) * 32'(COLUMN_BYTES) +
                    (32'(SCREEN_HEIGHT - 1) - 32'(sy[COORD_W-2:0])) *
                    32'(BYTES_PER_PIXEL);

  always_comb begin
    busy_nxt = busy_r;
    xs_nxt = xs_r;
    ys_nxt = ys_r;
    if (emit) begin
      if (xs_r == cur_r.scale - SCALE_W'(1)) begin
        xs_nxt = '0;
        ys_nxt = ys_r + SCALE_W'(1);
      end else begin
        xs_nxt = xs_r + SCALE_W'(1);
      end
      if (last) begin
        busy_nxt = 1'b0;
      end
    end
    if (load) begin
      busy_nxt = 1'b1;
      xs_nxt = '0;
      ys_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= head.entry;
    end
    if (emit) begin
      off_r <= on_screen ? off_full[OFFSET_W-1:0] : '0;
      blue_r <= cur_r.color[23:16];
      green_r <= cur_r.color[15:8];
      red_r <= cur_r.color[7:0];
      inb_r <= on_screen;
      last_r <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      xs_r <= '0;
      ys_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      xs_r <= xs_nxt;
      ys_r <= ys_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_rep.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_rep.valid = out_valid_r;
  assign out_rep.byte_offset = off_r;
  assign out_rep.blue_byte = blue_r;
  assign out_rep.green_byte = green_r;
  assign out_rep.red_byte = red_r;
  assign out_rep.in_bounds = inb_r;
  assign out_rep.last_replica = last_r;

endmodule

/* hw/rtl/scaled_rotated_pixel_blit.sv */
`timescale 1ns / 1ps
// Nearest-neighbor upscaling blit onto a rotated 400x240-style framebuffer. Source pixels
// arrive in raster order as packed words (red 7:0, green 15:8, blue 23:16); each one is
// replicated scale x scale times, centred on the screen, and every replica leaves as one
// item carrying the byte offset of its blue byte (column-major, y flipped, 3 bytes per
// pixel), the color bytes, an in-bounds flag (offset forced to 0 when off screen) and a
// last-replica flag. Replica order is row-major within the block (x inner). The back-end
// replica counter gives one replica per cycle unless the output stalls; a 2-deep queue
// lets the front take the next pixel while the current one is still being replicated.
// Source column/row counters wrap at the end of each line and frame. The registers
// (width at 0x0, height at 0x4, scale at 0x8) must be written over APB only while idle;
// the block does not check it. A scale or size of 0 acts as 1, above MAX_SCALE saturates.
module scaled_rotated_pixel_blit
  import srpb_pkg::*;
#(
  parameter int MAX_SCALE = 8,
  parameter int SCREEN_WIDTH = 400,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic               clk,
  input  logic               rst_n,
  srpb_px_if.sink            in_px,
  srpb_rep_if.source         out_rep,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t cfg_r;
  q_slot_t push, head;
  logic push_ready, pop;
  logic cfg_wr;

  // register file, write on the apb access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.render_width <= RENDER_WIDTH_RST;
      cfg_r.render_height <= RENDER_HEIGHT_RST;
      cfg_r.scale_factor <= SCALE_FACTOR_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_RENDER_WIDTH: cfg_r.render_width <= pwdata[WIDTH_W-1:0];
        REG_RENDER_HEIGHT: cfg_r.render_height <= pwdata[HEIGHT_W-1:0];
        REG_SCALE_FACTOR: cfg_r.scale_factor <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // readback
  always_comb begin
    case (paddr[3:2])
      REG_RENDER_WIDTH: prdata = 32'(cfg_r.render_width);
      REG_RENDER_HEIGHT: prdata = 32'(cfg_r.render_height);
      REG_SCALE_FACTOR: prdata = 32'(cfg_r.scale_factor);
      default: prdata = '0;
    endcase
  end

  // front: takes pixels, works out the replica block origin, advances the raster counters
  srpb_front #(
    .MAX_SCALE(MAX_SCALE),
    .SCREEN_WIDTH(SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .cfg(cfg_r),
    .in_px(in_px),
    .push(push),
    .push_ready(push_ready)
  );

  // decoupling queue between front and back
  srpb_queue u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .push_ready(push_ready),
    .head(head),
    .pop(pop)
  );

  // back: walks the scale x scale replicas and drives the registered result
  srpb_back #(
    .SCREEN_WIDTH(SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .head(head),
    .pop(pop),
    .out_rep(out_rep)
  );

endmodule
